// ===== rtl/core/grid_trace_clip_ramp_window_assert.svh =====
// ----------------------------------------------------------------------------
// Grid trace clip ramp window assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef GRID_TRACE_CLIP_RAMP_WINDOW_ASSERT_SVH
`define GRID_TRACE_CLIP_RAMP_WINDOW_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GTCRW_ASSERT_IMPLY(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("gtcrw same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GTCRW_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("gtcrw next-cycle check failed");

`endif

// ===== rtl/core/gtcrw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtcrw_pkg
// Shared constants, register indexes and inter-module types.
// ----------------------------------------------------------------------------
package gtcrw_pkg;

  localparam int COORD_BITS_DEF  = 12;
  localparam int SAMPLE_BITS_DEF = 32;
  localparam int DATA_W          = 32;
  localparam int CFG_W           = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int MODE_W          = 3;
  localparam int GRID_W          = 60;
  localparam int DIMS            = 5;
  localparam int OUTER_DIMS      = 4;
  localparam int FIFO_DEPTH      = 4;
  localparam int DIV_BITS        = 33;
  localparam int QUOT_W          = 34;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOWER_CLIP = 3'd0,
    REG_UPPER_CLIP = 3'd1,
    REG_CLIP_MODE  = 3'd2,
    REG_FILL_VALUE = 3'd3,
    REG_RAMP_ENDS  = 3'd4,
    REG_GRID_SIZE  = 3'd5,
    REG_ZONE_LOW   = 3'd6,
    REG_ZONE_HIGH  = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_PASS  = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2
  } item_op_t;

  typedef struct packed {
    item_op_t op;
    logic     pass;
    logic     tend;
    logic     gend;
    logic     first;
  } item_ctl_t;

  typedef struct packed {
    logic                     busy;
    logic signed [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/core/gtcrw_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtcrw_fifo
// Short register queue between the classifying front end and the back end.
// ----------------------------------------------------------------------------
module gtcrw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = gtcrw_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/gtcrw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtcrw_front
// Accepts samples, tracks grid position and classifies each beat.
// ----------------------------------------------------------------------------
module gtcrw_front #(
  parameter int COORD_BITS = gtcrw_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [gtcrw_pkg::DATA_W-1:0]   sample_in,
  input  logic signed [gtcrw_pkg::DATA_W-1:0]   lower_clip,
  input  logic signed [gtcrw_pkg::DATA_W-1:0]   upper_clip,
  input  logic [gtcrw_pkg::MODE_W-1:0]          clip_mode,
  input  logic [gtcrw_pkg::GRID_W-1:0]          grid_size,
  input  logic [gtcrw_pkg::GRID_W-1:0]          zone_low,
  input  logic [gtcrw_pkg::GRID_W-1:0]          zone_high,
  input  logic                                  full,
  output logic                                  push,
  output gtcrw_pkg::item_ctl_t                  push_ctl,
  output logic [COORD_BITS-1:0]                 push_rem,
  output logic signed [gtcrw_pkg::DATA_W-1:0]   push_sample
);

  logic [COORD_BITS-1:0]                             sample_index;
  logic [gtcrw_pkg::OUTER_DIMS-1:0][COORD_BITS-1:0]  trace_coords;
  logic                                              search_open;
  logic                                              ramp_active;

  logic [COORD_BITS-1:0]                             index_next;
  logic [gtcrw_pkg::OUTER_DIMS-1:0][COORD_BITS-1:0]  coords_next;
  logic [gtcrw_pkg::DIMS-1:0][COORD_BITS-1:0]        coords;
  logic                                              search_next;
  logic                                              ramp_next;
  logic                                              idx0;
  logic                                              so;
  logic                                              ra;
  logic                                              carry;
  logic [COORD_BITS-1:0]                             size0;
  logic signed [gtcrw_pkg::DATA_W-1:0]               xl;

  assign in_stall = full;
  assign push     = in_valid && !full;

  always_comb begin
    idx0  = (sample_index == '0);
    so    = idx0 || search_open;
    ra    = !idx0 && ramp_active;
    size0 = grid_size[COORD_BITS-1:0];
    xl    = (clip_mode[0] && (sample_in < lower_clip)) ? lower_clip : sample_in;

    push_ctl.op    = gtcrw_pkg::OP_PASS;
    push_ctl.first = idx0 && (trace_coords == '0);
    push_sample    = xl;
    search_next    = so;
    ramp_next      = ra;

    if (clip_mode[2]) begin
      if (ra) begin
        push_ctl.op = gtcrw_pkg::OP_STEP;
      end else if (so && (xl > upper_clip)) begin
        search_next = 1'b0;
        if (!idx0) begin
          push_ctl.op = gtcrw_pkg::OP_START;
          ramp_next   = 1'b1;
        end
      end
    end else if (clip_mode[1] && (xl > upper_clip)) begin
      push_sample = upper_clip;
    end

    push_ctl.tend = (sample_index >= size0);
    push_rem      = (sample_index < size0) ? (size0 - sample_index) : '0;

    coords[0] = sample_index;
    for (int d = 0; d < gtcrw_pkg::OUTER_DIMS; d++) begin
      coords[d+1] = trace_coords[d];
    end
    push_ctl.pass = 1'b1;
    for (int d = 0; d < gtcrw_pkg::DIMS; d++) begin
      if ((coords[d] < zone_low[d*COORD_BITS +: COORD_BITS]) ||
          (coords[d] > zone_high[d*COORD_BITS +: COORD_BITS])) begin
        push_ctl.pass = 1'b0;
      end
    end

    carry = push_ctl.tend;
    for (int d = 0; d < gtcrw_pkg::OUTER_DIMS; d++) begin
      coords_next[d] = trace_coords[d];
      if (carry) begin
        if (trace_coords[d] >= grid_size[(d+1)*COORD_BITS +: COORD_BITS]) begin
          coords_next[d] = '0;
        end else begin
          coords_next[d] = trace_coords[d] + 1'b1;
          carry          = 1'b0;
        end
      end
    end
    push_ctl.gend = carry;

    if (push_ctl.tend) begin
      index_next = '0;
      ramp_next  = 1'b0;
    end else begin
      index_next = sample_index + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      trace_coords <= '0;
      search_open  <= 1'b1;
      ramp_active  <= 1'b0;
    end else if (push) begin
      sample_index <= index_next;
      trace_coords <= coords_next;
      search_open  <= search_next;
      ramp_active  <= ramp_next;
    end
  end

endmodule

// ===== rtl/core/gtcrw_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtcrw_div
// Radix-2 restoring divider for the ramp step, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gtcrw_div #(
  parameter int COORD_BITS = gtcrw_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [gtcrw_pkg::DIV_BITS-1:0] dividend,
  input  logic [COORD_BITS-1:0]                 divisor,
  output gtcrw_pkg::div_rsp_t                   rsp
);

  localparam int DB    = gtcrw_pkg::DIV_BITS;
  localparam int QW    = gtcrw_pkg::QUOT_W;
  localparam int CNT_W = $clog2(DB + 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [COORD_BITS-1:0] acc;
  logic [DB-1:0]         q;
  logic [COORD_BITS-1:0] dvsr;
  logic                  neg;

  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS:0]   diff;
  logic                  ge;
  logic [DB-1:0]         mag;
  logic signed [QW-1:0]  quot_mag;

  always_comb begin
    trial    = {acc, q[DB-1]};
    diff     = trial - {1'b0, dvsr};
    ge       = (trial >= {1'b0, dvsr});
    mag      = dividend[DB-1] ? DB'(-dividend) : dividend;
    quot_mag = signed'({1'b0, q});
    rsp.busy = busy;
    rsp.quot = neg ? -quot_mag : quot_mag;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      q    <= mag;
      dvsr <= divisor;
      neg  <= dividend[DB-1];
    end else if (busy) begin
      acc <= ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      q   <= {q[DB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DB);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/gtcrw_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtcrw_back
// Executes classified beats: ramp generation, fill, min/max and result register.
// ----------------------------------------------------------------------------
`include "grid_trace_clip_ramp_window_assert.svh"

module gtcrw_back #(
  parameter int COORD_BITS  = gtcrw_pkg::COORD_BITS_DEF,
  parameter int SAMPLE_BITS = gtcrw_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  head_valid,
  input  gtcrw_pkg::item_ctl_t                  head_ctl,
  input  logic [COORD_BITS-1:0]                 head_rem,
  input  logic signed [gtcrw_pkg::DATA_W-1:0]   head_sample,
  output logic                                  pop,
  input  logic signed [gtcrw_pkg::DATA_W-1:0]   fill_value,
  input  logic [gtcrw_pkg::CFG_W-1:0]           ramp_ends,
  output logic                                  div_start,
  output logic signed [gtcrw_pkg::DIV_BITS-1:0] div_dividend,
  output logic [COORD_BITS-1:0]                 div_divisor,
  input  gtcrw_pkg::div_rsp_t                   div_rsp,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [gtcrw_pkg::DATA_W-1:0]   sample_out,
  output logic                                  trace_end,
  output logic                                  grid_end,
  output logic signed [gtcrw_pkg::DATA_W-1:0]   grid_min,
  output logic signed [gtcrw_pkg::DATA_W-1:0]   grid_max
);

  localparam int QW = gtcrw_pkg::QUOT_W;
  localparam int DW = gtcrw_pkg::DATA_W;
  localparam logic signed [QW-1:0] SMAX_W =
    {{(QW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [QW-1:0] SMIN_W = ~SMAX_W;

  typedef enum logic [1:0] {
    BS_RUN = 2'b01,
    BS_DIV = 2'b10
  } back_state_t;

  back_state_t state;
  back_state_t state_next;

  logic signed [SAMPLE_BITS-1:0] ramp_level;
  logic signed [SAMPLE_BITS-1:0] ramp_step;

  logic                          can_out;
  logic                          produce;
  logic signed [DW-1:0]          rbeg;
  logic signed [DW-1:0]          rend;
  logic signed [SAMPLE_BITS-1:0] level_start;
  logic signed [SAMPLE_BITS-1:0] level_add;
  logic signed [SAMPLE_BITS-1:0] step_new;
  logic signed [DW-1:0]          x;
  logic signed [DW-1:0]          min_next;
  logic signed [DW-1:0]          max_next;

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [QW-1:0] v);
    logic signed [SAMPLE_BITS-1:0] r;
    if (v > SMAX_W) begin
      r = SMAX_W[SAMPLE_BITS-1:0];
    end else if (v < SMIN_W) begin
      r = SMIN_W[SAMPLE_BITS-1:0];
    end else begin
      r = v[SAMPLE_BITS-1:0];
    end
    return r;
  endfunction

  always_comb begin
    can_out      = !out_valid || !out_stall;
    rbeg         = signed'(ramp_ends[DW-1:0]);
    rend         = signed'(ramp_ends[2*DW-1:DW]);
    div_dividend = gtcrw_pkg::DIV_BITS'(rend) - gtcrw_pkg::DIV_BITS'(rbeg);
    div_divisor  = head_rem;
    level_start  = sat(QW'(rbeg));
    level_add    = sat(QW'(ramp_level) + QW'(ramp_step));
    step_new     = (head_rem == '0) ? '0 : sat(div_rsp.quot);

    div_start = (state == BS_RUN) && head_valid && can_out &&
                (head_ctl.op == gtcrw_pkg::OP_START) && (head_rem != '0);
    produce   = head_valid && can_out &&
                (((state == BS_RUN) && !div_start) ||
                 ((state == BS_DIV) && !div_rsp.busy));
    pop       = produce;

    case (head_ctl.op)
      gtcrw_pkg::OP_START: x = DW'(level_start);
      gtcrw_pkg::OP_STEP:  x = DW'(level_add);
      default:             x = head_sample;
    endcase
    if (!head_ctl.pass) begin
      x = fill_value;
    end

    if (head_ctl.first) begin
      min_next = x;
      max_next = x;
    end else begin
      min_next = (x < grid_min) ? x : grid_min;
      max_next = (x > grid_max) ? x : grid_max;
    end

    state_next = state;
    unique case (state)
      BS_RUN: begin
        if (div_start) begin
          state_next = BS_DIV;
        end
      end
      BS_DIV: begin
        if (produce) begin
          state_next = BS_RUN;
        end
      end
      default: state_next = BS_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BS_RUN;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (produce) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_level <= '0;
      ramp_step  <= '0;
    end else if (produce) begin
      if (head_ctl.op == gtcrw_pkg::OP_START) begin
        ramp_level <= level_start;
        ramp_step  <= step_new;
      end else if (head_ctl.op == gtcrw_pkg::OP_STEP) begin
        ramp_level <= level_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      sample_out <= x;
      trace_end  <= head_ctl.tend;
      grid_end   <= head_ctl.gend;
      grid_min   <= min_next;
      grid_max   <= max_next;
    end
  end

  `GTCRW_ASSERT_NEXT(a_launch_busy, div_start, div_rsp.busy)
  `GTCRW_ASSERT_IMPLY(a_div_head, state == BS_DIV, head_valid && head_ctl.op == gtcrw_pkg::OP_START)
  `GTCRW_ASSERT_IMPLY(a_pop_head, pop, head_valid && can_out)
  `GTCRW_ASSERT_IMPLY(a_grid_in_trace, out_valid && grid_end, trace_end)

endmodule

// ===== rtl/core/grid_trace_clip_ramp_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_trace_clip_ramp_window
// Clip, ramp and pass-zone window over a five-dimensional sample grid.
// ----------------------------------------------------------------------------
// Samples enter in trace order, one beat per cycle while the queue is not full,
// and each produces one result beat. The front end counts grid position,
// applies the lower and upper clamps and classifies the beat; a four-entry
// queue feeds the back end, which builds ramps, applies the fill value and
// tracks grid min/max into an output register. Ordinary beats pass through the
// back end without waiting on the divider. The beat that starts a ramp with a
// nonzero remaining length holds the back end while the 33-bit radix-2 step
// divider runs; that beat stays at the head of the queue, so the queue keeps
// taking up to three more beats meanwhile. Configuration takes effect in the cycle after the write.
module grid_trace_clip_ramp_window #(
  parameter int COORD_BITS  = gtcrw_pkg::COORD_BITS_DEF,
  parameter int SAMPLE_BITS = gtcrw_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [gtcrw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gtcrw_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [gtcrw_pkg::DATA_W-1:0]  sample_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [gtcrw_pkg::DATA_W-1:0]  sample_out,
  output logic                                 trace_end,
  output logic                                 grid_end,
  output logic signed [gtcrw_pkg::DATA_W-1:0]  grid_min,
  output logic signed [gtcrw_pkg::DATA_W-1:0]  grid_max
);

  localparam int DW      = gtcrw_pkg::DATA_W;
  localparam int ENTRY_W = $bits(gtcrw_pkg::item_ctl_t) + COORD_BITS + DW;

  logic signed [DW-1:0]                lower_clip;
  logic signed [DW-1:0]                upper_clip;
  logic [gtcrw_pkg::MODE_W-1:0]        clip_mode;
  logic signed [DW-1:0]                fill_value;
  logic [gtcrw_pkg::CFG_W-1:0]         ramp_ends;
  logic [gtcrw_pkg::GRID_W-1:0]        grid_size;
  logic [gtcrw_pkg::GRID_W-1:0]        zone_low;
  logic [gtcrw_pkg::GRID_W-1:0]        zone_high;

  logic                                push;
  gtcrw_pkg::item_ctl_t                push_ctl;
  logic [COORD_BITS-1:0]               push_rem;
  logic signed [DW-1:0]                push_sample;
  logic                                full;
  logic                                empty;
  logic                                pop;
  logic [ENTRY_W-1:0]                  rdata;
  gtcrw_pkg::item_ctl_t                head_ctl;
  logic [COORD_BITS-1:0]               head_rem;
  logic signed [DW-1:0]                head_sample;

  logic                                div_start;
  logic signed [gtcrw_pkg::DIV_BITS-1:0] div_dividend;
  logic [COORD_BITS-1:0]               div_divisor;
  gtcrw_pkg::div_rsp_t                 div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_clip <= signed'({1'b1, {(DW-1){1'b0}}});
      upper_clip <= signed'({1'b0, {(DW-1){1'b1}}});
      clip_mode  <= '0;
      fill_value <= '0;
      ramp_ends  <= '0;
      grid_size  <= '0;
      zone_low   <= '0;
      zone_high  <= '0;
    end else if (cfg_write) begin
      unique case (gtcrw_pkg::cfg_reg_t'(cfg_index))
        gtcrw_pkg::REG_LOWER_CLIP: lower_clip <= signed'(cfg_data[DW-1:0]);
        gtcrw_pkg::REG_UPPER_CLIP: upper_clip <= signed'(cfg_data[DW-1:0]);
        gtcrw_pkg::REG_CLIP_MODE:  clip_mode  <= cfg_data[gtcrw_pkg::MODE_W-1:0];
        gtcrw_pkg::REG_FILL_VALUE: fill_value <= signed'(cfg_data[DW-1:0]);
        gtcrw_pkg::REG_RAMP_ENDS:  ramp_ends  <= cfg_data;
        gtcrw_pkg::REG_GRID_SIZE:  grid_size  <= cfg_data[gtcrw_pkg::GRID_W-1:0];
        gtcrw_pkg::REG_ZONE_LOW:   zone_low   <= cfg_data[gtcrw_pkg::GRID_W-1:0];
        gtcrw_pkg::REG_ZONE_HIGH:  zone_high  <= cfg_data[gtcrw_pkg::GRID_W-1:0];
        default: ;
      endcase
    end
  end

  gtcrw_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample_in   (sample_in),
    .lower_clip  (lower_clip),
    .upper_clip  (upper_clip),
    .clip_mode   (clip_mode),
    .grid_size   (grid_size),
    .zone_low    (zone_low),
    .zone_high   (zone_high),
    .full        (full),
    .push        (push),
    .push_ctl    (push_ctl),
    .push_rem    (push_rem),
    .push_sample (push_sample)
  );

  gtcrw_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (gtcrw_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata ({push_ctl, push_rem, push_sample}),
    .pop   (pop),
    .rdata (rdata),
    .full  (full),
    .empty (empty)
  );

  assign head_sample = signed'(rdata[DW-1:0]);
  assign head_rem    = rdata[DW +: COORD_BITS];
  assign head_ctl    = gtcrw_pkg::item_ctl_t'(rdata[ENTRY_W-1 -: $bits(gtcrw_pkg::item_ctl_t)]);

  gtcrw_div #(
    .COORD_BITS (COORD_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .rsp      (div_rsp)
  );

  gtcrw_back #(
    .COORD_BITS  (COORD_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (!empty),
    .head_ctl     (head_ctl),
    .head_rem     (head_rem),
    .head_sample  (head_sample),
    .pop          (pop),
    .fill_value   (fill_value),
    .ramp_ends    (ramp_ends),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_rsp      (div_rsp),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_out   (sample_out),
    .trace_end    (trace_end),
    .grid_end     (grid_end),
    .grid_min     (grid_min),
    .grid_max     (grid_max)
  );

endmodule

// ===== verif/tb_grid_trace_clip_ramp_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_trace_clip_ramp_window
// Self-checking bench for the grid trace clip, ramp and window block.
// ----------------------------------------------------------------------------
// A behavioral copy of the block tracks grid position, clamps, ramps, pass
// zone and grid min/max, and predicts every result beat as each sample beat
// is accepted. Directed traces cover the clamps, every ramp corner, fill
// and counters left beyond a shrunken size. Random phases follow with fresh
// register settings each time and random idling on both sides.
// ----------------------------------------------------------------------------
module tb_grid_trace_clip_ramp_window;

  localparam int CB = gtcrw_pkg::COORD_BITS_DEF;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -Q_MAX - 1;

  typedef struct packed {
    logic [31:0] data;
    logic [31:0] last_in_trace;
    logic [31:0] last_in_grid;
    logic [31:0] min_val;
    logic [31:0] max_val;
  } grid_result_t;

  typedef struct {
    logic [31:0] lower;
    logic [31:0] upper;
    logic [2:0]  mode;
    logic [31:0] fill;
    logic [63:0] ramp;
    logic [59:0] size;
    logic [59:0] zlo;
    logic [59:0] zhi;
  } clip_settings_t;

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                cfg_write;
  gtcrw_pkg::cfg_reg_t                 cfg_index;
  logic [gtcrw_pkg::CFG_W-1:0]         cfg_data;
  logic                                in_valid;
  logic                                in_stall;
  logic signed [gtcrw_pkg::DATA_W-1:0] sample_in;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [gtcrw_pkg::DATA_W-1:0] sample_out;
  logic                                trace_end;
  logic                                grid_end;
  logic signed [gtcrw_pkg::DATA_W-1:0] grid_min;
  logic signed [gtcrw_pkg::DATA_W-1:0] grid_max;

  grid_trace_clip_ramp_window dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample_out (sample_out),
    .trace_end  (trace_end),
    .grid_end   (grid_end),
    .grid_min   (grid_min),
    .grid_max   (grid_max)
  );

  always #4 clk = ~clk;

  // Mirror of the register file.
  longint      cfg_lower, cfg_upper, cfg_fill;
  logic [2:0]  cfg_mode;
  logic [63:0] cfg_ramp;
  logic [59:0] cfg_size, cfg_zlo, cfg_zhi;

  // Mirror of the grid position and ramp state.
  longint trace_pos;
  longint outer_pos [4];
  bit     search_open, ramp_on;
  longint ramp_level, ramp_inc, seen_min, seen_max;

  grid_result_t results_due [$];
  int pending = 0;
  int errors = 0;
  int sent_count = 0;
  bit calm = 1'b0;
  bit idle_on = 1'b1;
  int stall_left = 0;

  function automatic longint clamp_q16(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic longint dim_of(input logic [59:0] r, input int d);
    return longint'((r >> (CB * d)) & 60'hFFF);
  endfunction

  function automatic logic [59:0] pack_dims(input logic [11:0] d0, input logic [11:0] d1,
                                            input logic [11:0] d2, input logic [11:0] d3,
                                            input logic [11:0] d4);
    return {d4, d3, d2, d1, d0};
  endfunction

  task automatic reset_model();
    cfg_lower = Q_MIN;
    cfg_upper = Q_MAX;
    cfg_mode = 3'd0;
    cfg_fill = 0;
    cfg_ramp = '0;
    cfg_size = '0;
    cfg_zlo = '0;
    cfg_zhi = '0;
    trace_pos = 0;
    for (int d = 0; d < 4; d++) outer_pos[d] = 0;
    search_open = 1'b1;
    ramp_on = 1'b0;
    ramp_level = 0;
    ramp_inc = 0;
    seen_min = 0;
    seen_max = 0;
  endtask

  function automatic grid_result_t process_grid_sample(input logic signed [31:0] din);
    longint x, rbeg, rend, rem, last0;
    longint pos [5];
    bit first_of_grid, in_zone, at_trace_end, carried;
    grid_result_t r;
    x = din;
    last0 = dim_of(cfg_size, 0);
    first_of_grid = (trace_pos == 0);
    for (int d = 0; d < 4; d++) if (outer_pos[d] != 0) first_of_grid = 1'b0;
    if (trace_pos == 0) begin
      search_open = 1'b1;
      ramp_on = 1'b0;
    end
    if (cfg_mode[0] && x < cfg_lower) x = cfg_lower;
    if (cfg_mode[2]) begin
      if (ramp_on) begin
        ramp_level = clamp_q16(ramp_level + ramp_inc);
        x = ramp_level;
      end else if (search_open && x > cfg_upper) begin
        search_open = 1'b0;
        if (trace_pos != 0) begin
          rbeg = $signed(cfg_ramp[31:0]);
          rend = $signed(cfg_ramp[63:32]);
          rem = (trace_pos < last0) ? last0 - trace_pos : 0;
          ramp_inc = (rem > 0) ? clamp_q16((rend - rbeg) / rem) : 0;
          ramp_on = 1'b1;
          ramp_level = clamp_q16(rbeg);
          x = ramp_level;
        end
      end
    end else if (cfg_mode[1] && x > cfg_upper) begin
      x = cfg_upper;
    end
    pos[0] = trace_pos;
    for (int d = 0; d < 4; d++) pos[d + 1] = outer_pos[d];
    in_zone = 1'b1;
    for (int d = 0; d < 5; d++) begin
      if (pos[d] < dim_of(cfg_zlo, d) || pos[d] > dim_of(cfg_zhi, d)) in_zone = 1'b0;
    end
    if (!in_zone) x = cfg_fill;
    if (first_of_grid) begin
      seen_min = x;
      seen_max = x;
    end else begin
      if (x < seen_min) seen_min = x;
      if (x > seen_max) seen_max = x;
    end
    at_trace_end = (trace_pos >= last0);
    carried = 1'b0;
    if (at_trace_end) begin
      trace_pos = 0;
      ramp_on = 1'b0;
      carried = 1'b1;
      for (int d = 0; d < 4; d++) begin
        if (carried) begin
          if (outer_pos[d] >= dim_of(cfg_size, d + 1)) begin
            outer_pos[d] = 0;
          end else begin
            outer_pos[d] = (outer_pos[d] + 1) & 'hFFF;
            carried = 1'b0;
          end
        end
      end
    end else begin
      trace_pos = (trace_pos + 1) & 'hFFF;
    end
    r.data = x[31:0];
    r.last_in_trace = {31'd0, at_trace_end};
    r.last_in_grid = {31'd0, carried};
    r.min_val = seen_min[31:0];
    r.max_val = seen_max[31:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Mirror register writes, predict accepted sample beats and check result beats.
  always @(posedge clk) begin : scoreboard
    grid_result_t due;
    if (rst) begin
      reset_model();
      results_due.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          gtcrw_pkg::REG_LOWER_CLIP: cfg_lower = $signed(cfg_data[31:0]);
          gtcrw_pkg::REG_UPPER_CLIP: cfg_upper = $signed(cfg_data[31:0]);
          gtcrw_pkg::REG_CLIP_MODE:  cfg_mode = cfg_data[2:0];
          gtcrw_pkg::REG_FILL_VALUE: cfg_fill = $signed(cfg_data[31:0]);
          gtcrw_pkg::REG_RAMP_ENDS:  cfg_ramp = cfg_data;
          gtcrw_pkg::REG_GRID_SIZE:  cfg_size = cfg_data[59:0];
          gtcrw_pkg::REG_ZONE_LOW:   cfg_zlo = cfg_data[59:0];
          gtcrw_pkg::REG_ZONE_HIGH:  cfg_zhi = cfg_data[59:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) results_due.push_back(process_grid_sample(sample_in));
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h", $time,
                   sample_out);
          errors++;
        end else begin
          due = results_due.pop_front();
          check_field("sample_out", due.data, sample_out);
          check_field("trace_end", due.last_in_trace, {31'd0, trace_end});
          check_field("grid_end", due.last_in_grid, {31'd0, grid_end});
          check_field("grid_min", due.min_val, grid_min);
          check_field("grid_max", due.max_val, grid_max);
        end
      end
    end
    pending <= results_due.size();
  end

  // Output side back-pressure in random bursts.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (calm || !idle_on) begin
        out_stall <= 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(1, 13) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #6000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic clip_settings_t base_settings();
    clip_settings_t s;
    s.lower = 32'h8000_0000;
    s.upper = 32'h7FFF_FFFF;
    s.mode = 3'd0;
    s.fill = 32'h0;
    s.ramp = 64'h0;
    s.size = '0;
    s.zlo = '0;
    s.zhi = '1;
    return s;
  endfunction

  task automatic load_settings(input clip_settings_t s);
    cfg_write <= 1'b1;
    cfg_index <= gtcrw_pkg::REG_LOWER_CLIP;
    cfg_data <= {$urandom, s.lower};
    @(posedge clk);
    cfg_index <= gtcrw_pkg::REG_UPPER_CLIP;
    cfg_data <= {$urandom, s.upper};
    @(posedge clk);
    cfg_index <= gtcrw_pkg::REG_CLIP_MODE;
    cfg_data <= {$urandom, 15'($urandom_range(0, 15'h7FFF)), 14'd0, s.mode};
    @(posedge clk);
    cfg_index <= gtcrw_pkg::REG_FILL_VALUE;
    cfg_data <= {$urandom, s.fill};
    @(posedge clk);
    cfg_index <= gtcrw_pkg::REG_RAMP_ENDS;
    cfg_data <= s.ramp;
    @(posedge clk);
    cfg_index <= gtcrw_pkg::REG_GRID_SIZE;
    cfg_data <= {4'($urandom), s.size};
    @(posedge clk);
    cfg_index <= gtcrw_pkg::REG_ZONE_LOW;
    cfg_data <= {4'($urandom), s.zlo};
    @(posedge clk);
    cfg_index <= gtcrw_pkg::REG_ZONE_HIGH;
    cfg_data <= {4'($urandom), s.zhi};
    @(posedge clk);
    cfg_write <= 1'b0;
    // Let the new settings reach the front end.
    repeat (2) @(posedge clk);
  endtask

  task automatic send_sample(input logic [31:0] v);
    if (idle_on && !calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic test_power_on();
    logic [31:0] seq [4];
    seq = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
    foreach (seq[i]) send_sample(seq[i]);
    drain_results();
  endtask

  task automatic test_clamps();
    clip_settings_t s;
    logic [31:0] seq [4];
    s = base_settings();
    s.lower = 32'hFFFF_0000;
    s.upper = 32'h0002_0000;
    s.mode = 3'd3;
    s.fill = 32'h1234_5678;
    s.size = pack_dims(12'd3, 12'd0, 12'd0, 12'd0, 12'd0);
    s.zlo = pack_dims(12'd1, 12'd0, 12'd0, 12'd0, 12'd0);
    load_settings(s);
    seq = '{32'h0000_0005, 32'h8000_0000, 32'h0002_0000, 32'h7FFF_FFFF};
    foreach (seq[i]) send_sample(seq[i]);
    drain_results();
  endtask

  task automatic test_ramp_cases();
    clip_settings_t s;
    logic [31:0] seq [12];
    logic [31:0] sat_seq [3];
    s = base_settings();
    s.lower = 32'hFFFF_0000;
    s.upper = 32'h0;
    s.mode = 3'd7;
    s.ramp = {32'h0005_0000, 32'h0001_0000};
    s.size = pack_dims(12'd3, 12'd0, 12'd0, 12'd0, 12'd0);
    load_settings(s);
    // Trigger on sample zero, trigger mid-trace, trigger on the last sample.
    seq = '{32'h1, 32'hFFFF_FFFF, 32'h5, 32'h5,
            32'hFFFF_FFFF, 32'h7, 32'h3, 32'hFFFF_FFFB,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h9};
    foreach (seq[i]) send_sample(seq[i]);
    drain_results();
    // Ramp step that saturates over a single remaining sample.
    s.ramp = {32'h7FFF_FFFF, 32'h8000_0000};
    s.size = pack_dims(12'd2, 12'd0, 12'd0, 12'd0, 12'd0);
    load_settings(s);
    sat_seq = '{32'hFFFF_FFFF, 32'h5, 32'h3};
    foreach (sat_seq[i]) send_sample(sat_seq[i]);
    drain_results();
  endtask

  task automatic test_size_shrink();
    clip_settings_t s;
    s = base_settings();
    s.size = pack_dims(12'd7, 12'd0, 12'd0, 12'd0, 12'd0);
    load_settings(s);
    repeat (3) send_sample($urandom);
    drain_results();
    // Counter now sits beyond the new size; zone range is empty.
    s.size = pack_dims(12'd1, 12'd0, 12'd0, 12'd0, 12'd0);
    s.zlo = pack_dims(12'd3, 12'd0, 12'd0, 12'd0, 12'd0);
    s.zhi = pack_dims(12'd1, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
    s.fill = 32'h8000_0000;
    load_settings(s);
    repeat (3) send_sample($urandom);
    drain_results();
  endtask

  function automatic logic [31:0] pick_level();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom & 32'h0003_FFFF;
      3: return $urandom | 32'hFFFC_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [11:0] pick_outer();
    case ($urandom_range(0, 11))
      0: return 12'($urandom_range(0, 4095));
      1, 2, 3: return 12'($urandom_range(1, 2));
      default: return 12'd0;
    endcase
  endfunction

  function automatic clip_settings_t random_settings();
    clip_settings_t s;
    logic [11:0] lo, hi;
    s.lower = pick_level();
    s.upper = pick_level();
    s.mode = 3'($urandom_range(0, 7));
    s.fill = pick_level();
    case ($urandom_range(0, 5))
      0: s.ramp = {32'h8000_0000, 32'h7FFF_FFFF};
      1: s.ramp = {32'h7FFF_FFFF, 32'h8000_0000};
      default: s.ramp = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 19))
      0: s.size[11:0] = 12'($urandom_range(0, 4095));
      1, 2: s.size[11:0] = 12'($urandom_range(0, 60));
      default: s.size[11:0] = 12'($urandom_range(0, 12));
    endcase
    for (int d = 1; d < 5; d++) s.size[CB*d +: CB] = pick_outer();
    for (int d = 0; d < 5; d++) begin
      lo = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 3)) : 12'd0;
      hi = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 6)) : 12'hFFF;
      s.zlo[CB*d +: CB] = lo;
      s.zhi[CB*d +: CB] = hi;
    end
    if ($urandom_range(0, 9) == 0) begin
      s.zlo = 60'({$urandom, $urandom});
      s.zhi = 60'({$urandom, $urandom});
    end
    return s;
  endfunction

  function automatic logic [31:0] pick_sample(input clip_settings_t s);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2: return s.upper + 32'($urandom_range(0, 4)) - 32'd2;
      3: return s.lower + 32'($urandom_range(0, 4)) - 32'd2;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random_grids();
    clip_settings_t s;
    int n;
    while (sent_count < 1300) begin
      s = random_settings();
      idle_on = ($urandom_range(0, 3) != 0);
      calm = (sent_count > 1100);
      load_settings(s);
      n = $urandom_range(10, 80);
      for (int i = 0; i < n && sent_count < 1300; i++) send_sample(pick_sample(s));
      drain_results();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = gtcrw_pkg::REG_LOWER_CLIP;
    cfg_data = '0;
    in_valid = 1'b0;
    sample_in = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_power_on();
    test_clamps();
    test_ramp_cases();
    test_size_shrink();
    test_random_grids();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
